[sv/ttw_pkg.sv]
// Shared types, constants and glyph functions of the text-to-tile-map writer.
package ttw_pkg;

	// Font and layer limits.
	localparam int LAST_GLYPH   = 113;
	localparam int MAX_TEXT_DIM = 64;

	// Default depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Character codes and glyph numbers.
	localparam logic [7:0] CODE_NEWLINE    = 8'd10;
	localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
	localparam logic [7:0] ASCII_END       = 8'd128;
	localparam logic [7:0] LATIN_BASE      = 8'd96;
	localparam logic [7:0] GLYPH_BREAK     = 8'd200;
	localparam int         LATIN_COUNT     = 18;

	// Tile numbering: the font sheet is 32 tiles wide, the bottom half lies one row below.
	localparam logic [7:0] TILE_ROW_MASK = ~8'd31;
	localparam logic [8:0] TILES_PER_ROW = 9'd32;
	localparam int         PAL_SHIFT     = 12;
	localparam int         TILE_W        = PAL_SHIFT;

	// Rotation codes.
	localparam logic [1:0] ROT_NONE = 2'd0;
	localparam logic [1:0] ROT_CW   = 2'd1;
	localparam logic [1:0] ROT_CCW  = 2'd2;
	localparam logic [1:0] ROT_BAD  = 2'd3;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_ROTATION = 2'd0;
	localparam logic [1:0] REG_PALETTE  = 2'd1;
	localparam logic [1:0] REG_LAST_COL = 2'd2;
	localparam logic [1:0] REG_LAST_ROW = 2'd3;

	typedef logic [7:0] latin_tab_t [LATIN_COUNT];

	// Latin-1 codes that have glyphs, in glyph order starting at LATIN_BASE.
	localparam latin_tab_t LATIN_CODES = '{
		8'd199, 8'd231, 8'd209, 8'd241, 8'd193, 8'd201, 8'd205, 8'd211, 8'd218,
		8'd225, 8'd233, 8'd237, 8'd243, 8'd250, 8'd239, 8'd252, 8'd161, 8'd191
	};

	typedef struct packed {
		logic [1:0] rotation;
		logic [3:0] palette;
		logic [5:0] last_col;
		logic [5:0] last_row;
	} cfg_t;

	// What the back has to do with one queued word.
	typedef enum logic [1:0] {
		OP_SET,
		OP_PRINT,
		OP_BREAK,
		OP_HOLD
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] col;
		logic [7:0] row;
		logic [7:0] glyph;
	} entry_t;

	function automatic logic [5:0] clamp_dim(input logic [5:0] d);
		logic [5:0] r;
		r = d;
		if (int'(d) > MAX_TEXT_DIM - 1) begin
			r = 6'(MAX_TEXT_DIM - 1);
		end
		return r;
	endfunction

	function automatic logic [7:0] map_glyph(input logic [7:0] code);
		logic [7:0] g;
		g = 8'd0;
		if (code == CODE_NEWLINE) begin
			g = GLYPH_BREAK;
		end else if (code >= FIRST_PRINTABLE && code < ASCII_END) begin
			g = code - FIRST_PRINTABLE;
		end else begin
			for (int i = 0; i < LATIN_COUNT; i++) begin
				if (LATIN_CODES[i] == code) begin
					g = LATIN_BASE + 8'(i);
				end
			end
		end
		return g;
	endfunction

	// Tile number of the top half of a glyph.
	function automatic logic [8:0] tile_top(input logic [7:0] g);
		return {1'b0, g & TILE_ROW_MASK} + {1'b0, g};
	endfunction

endpackage

[sv/ttw_if.sv]
// Handshake channels of the writer: character words in, tile-map writes out.
interface ttw_char_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [5:0] start_col;
	logic [5:0] start_row;
	logic [7:0] char_code;

	modport source(output valid, kind, start_col, start_row, char_code, input ready);
	modport sink(input valid, kind, start_col, start_row, char_code, output ready);
endinterface

interface ttw_tile_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] map_col;
	logic [6:0]        map_row;
	logic [15:0]       tile_entry;
	logic              last_write;

	modport source(output valid, map_col, map_row, tile_entry, last_write, input ready);
	modport sink(input valid, map_col, map_row, tile_entry, last_write, output ready);
endinterface

[sv/text_to_tilemap_writer.sv]
// Top level of the text-to-tile-map writer.
// This block writes text of an 8x16 font into a tile map. Each word on the chars channel
// either places the cursor (kind 0; the start column and row are rotated by the current
// rotation mode and are not clamped) or carries one Latin-1 byte (kind 1). Printable ASCII
// maps to glyph byte-32, eighteen Latin-1 codes (sixteen accented letters and the two
// inverted marks) map to glyphs 96 to 113, a newline breaks the line, and every other byte
// prints as a blank glyph. A printed glyph leaves on the tiles channel as two words, the top
// tile and then the bottom tile (last_write set), each carrying the palette in bits 15 to
// 12; the cursor then advances and wraps at the end of a line in the direction that the
// rotation mode gives. In clockwise rotation the bottom tile may land in column -1. Under
// rotation code 3 every word is taken and ignored. A printing character occupies the back
// end for its two tile-map writes, which both go out through the single output register;
// cursor placements, newlines and other non-printing words need no output slot. The front
// end classifies words as they arrive and parks them in a queue of QUEUE_DEPTH words, so
// the chars channel keeps accepting one word per cycle while the back end works or the
// tiles channel stalls, until the queue is full; a steady stream of characters is paced by
// the two writes per character. When the queue is empty, the word of a character passes
// through the queue and then the output register before its first write is presented on
// the tiles channel. Registers (byte addresses 0, 4, 8, 12): rotation_mode, palette_index,
// last_column, last_row; write them only while idle.
module text_to_tilemap_writer #(
	parameter int QUEUE_DEPTH = ttw_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	ttw_char_if.sink    chars,
	ttw_tile_if.source  tiles
);
	ttw_pkg::cfg_t   cfg;
	ttw_pkg::entry_t push_entry;
	ttw_pkg::entry_t head_entry;
	logic            push;
	logic            pop;
	logic            full;
	logic            empty;

	// Rotation, palette, layer size: kept stable by user while text is in flight, unchecked.
	ttw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Front end: glyph lookup and rotation of start positions on the incoming word.
	ttw_front u_front (
		.chars (chars),
		.cfg   (cfg),
		.full  (full),
		.push  (push),
		.entry (push_entry)
	);

	// Queue that lets the front keep accepting while the back end is busy or stalled.
	ttw_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.full     (full),
		.pop      (pop),
		.rd_entry (head_entry),
		.empty    (empty)
	);

	// Back end: cursor state, the two tile writes per glyph, and line wrapping.
	ttw_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.entry  (head_entry),
		.empty  (empty),
		.pop    (pop),
		.tiles  (tiles)
	);
endmodule

[sv/ttw_cfg.sv]
// Configuration registers of the writer behind an APB-style port.
module ttw_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output ttw_pkg::cfg_t     cfg
);
	ttw_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotation <= ttw_pkg::ROT_NONE;
			cfg_q.palette  <= 4'd0;
			cfg_q.last_col <= ttw_pkg::clamp_dim(6'd31);
			cfg_q.last_row <= ttw_pkg::clamp_dim(6'd11);
		end else if (wr_en) begin
			case (reg_idx)
				ttw_pkg::REG_ROTATION: cfg_q.rotation <= pwdata[1:0];
				ttw_pkg::REG_PALETTE:  cfg_q.palette  <= pwdata[3:0];
				ttw_pkg::REG_LAST_COL: cfg_q.last_col <= ttw_pkg::clamp_dim(pwdata[5:0]);
				ttw_pkg::REG_LAST_ROW: cfg_q.last_row <= ttw_pkg::clamp_dim(pwdata[5:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ttw_pkg::REG_ROTATION: prdata = {30'd0, cfg_q.rotation};
			ttw_pkg::REG_PALETTE:  prdata = {28'd0, cfg_q.palette};
			ttw_pkg::REG_LAST_COL: prdata = {26'd0, cfg_q.last_col};
			ttw_pkg::REG_LAST_ROW: prdata = {26'd0, cfg_q.last_row};
			default:               prdata = 32'd0;
		endcase
	end
endmodule

[sv/ttw_front.sv]
// Front of the writer: accepts character words, maps glyphs and rotates start positions.
module ttw_front (
	ttw_char_if.sink          chars,
	input  ttw_pkg::cfg_t     cfg,
	input  logic              full,
	output logic              push,
	output ttw_pkg::entry_t   entry
);
	logic [7:0] g;
	logic [7:0] x;
	logic [7:0] y;
	logic [7:0] w;
	logic [7:0] h;

	assign chars.ready = !full;

	// A word that arrives under the unused rotation code is taken and dropped.
	assign push = chars.valid && !full && (cfg.rotation != ttw_pkg::ROT_BAD);

	always_comb begin
		x = {2'b00, chars.start_col};
		y = {2'b00, chars.start_row};
		w = {2'b00, cfg.last_col};
		h = {2'b00, cfg.last_row};
		g = ttw_pkg::map_glyph(chars.char_code);
		entry.glyph = g;
		entry.col   = x;
		entry.row   = y;
		if (!chars.kind) begin
			entry.op = ttw_pkg::OP_SET;
			case (cfg.rotation)
				ttw_pkg::ROT_CW: begin
					entry.col = w - y;
					entry.row = x;
				end
				ttw_pkg::ROT_CCW: begin
					entry.col = y;
					entry.row = h - x;
				end
				default: ;
			endcase
		end else if (g == ttw_pkg::GLYPH_BREAK) begin
			entry.op = ttw_pkg::OP_BREAK;
		end else if (int'(g) <= ttw_pkg::LAST_GLYPH) begin
			entry.op = ttw_pkg::OP_PRINT;
		end else begin
			entry.op = ttw_pkg::OP_HOLD;
		end
	end
endmodule

[sv/ttw_queue.sv]
// Short first-in first-out queue between the front and the back.
module ttw_queue #(
	parameter int DEPTH = ttw_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ttw_pkg::entry_t   wr_entry,
	output logic              full,
	input  logic              pop,
	output ttw_pkg::entry_t   rd_entry,
	output logic              empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ttw_pkg::entry_t entries_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CW'(DEPTH)) || pop)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill count beyond its depth");
`endif
endmodule

[sv/ttw_back.sv]
// Back of the writer: keeps the cursor and issues the two tile-map writes of each glyph.
module ttw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ttw_pkg::cfg_t     cfg,
	input  ttw_pkg::entry_t   entry,
	input  logic              empty,
	output logic              pop,
	ttw_tile_if.source        tiles
);
	localparam int TILE_PAD = ttw_pkg::TILE_W;

	logic              out_valid_q;
	logic signed [7:0] col_q;
	logic [6:0]        row_q;
	logic [15:0]       tile_q;
	logic              last_q;
	logic              half_q;
	logic [7:0]        col2_q;
	logic [6:0]        row2_q;
	logic [15:0]       tile2_q;
	logic [7:0]        cur_col_q;
	logic [7:0]        cur_row_q;

	logic              slot_free;
	logic              load_second;
	logic              pop_print;
	logic              prt;
	logic              brk;
	logic signed [8:0] c9;
	logic signed [8:0] r9;
	logic signed [8:0] w9;
	logic signed [8:0] h9;
	logic signed [8:0] cn;
	logic signed [8:0] rn;
	logic signed [8:0] step;
	logic [7:0]        col_a;
	logic [7:0]        col_b;
	logic [6:0]        row_a;
	logic [6:0]        row_b;
	logic [8:0]        tile_a;
	logic [8:0]        tile_b;

	assign slot_free   = !out_valid_q || tiles.ready;
	assign load_second = half_q && slot_free;
	assign pop         = !half_q && !empty && (entry.op != ttw_pkg::OP_PRINT || slot_free);
	assign pop_print   = pop && (entry.op == ttw_pkg::OP_PRINT);

	assign tiles.valid      = out_valid_q;
	assign tiles.map_col    = col_q;
	assign tiles.map_row    = row_q;
	assign tiles.tile_entry = tile_q;
	assign tiles.last_write = last_q;

	// Write positions and tile numbers of the current glyph.
	always_comb begin
		tile_a = ttw_pkg::tile_top(entry.glyph);
		tile_b = tile_a + ttw_pkg::TILES_PER_ROW;
		if (cfg.rotation == ttw_pkg::ROT_NONE) begin
			col_a = cur_col_q;
			col_b = cur_col_q;
			row_a = {cur_row_q[5:0], 1'b0};
			row_b = {cur_row_q[5:0], 1'b1};
		end else begin
			col_a = {cur_col_q[6:0], 1'b0};
			col_b = (cfg.rotation == ttw_pkg::ROT_CW) ? col_a - 8'd1 : {cur_col_q[6:0], 1'b1};
			row_a = cur_row_q[6:0];
			row_b = cur_row_q[6:0];
		end
	end

	// Cursor advance and line wrap, worked in nine bits so that a step past 127 still compares.
	always_comb begin
		prt  = (entry.op == ttw_pkg::OP_PRINT);
		brk  = (entry.op == ttw_pkg::OP_BREAK);
		step = prt ? 9'sd1 : 9'sd0;
		c9   = {cur_col_q[7], cur_col_q};
		r9   = {cur_row_q[7], cur_row_q};
		w9   = {3'b000, cfg.last_col};
		h9   = {3'b000, cfg.last_row};
		cn   = c9;
		rn   = r9;
		if (entry.op == ttw_pkg::OP_SET) begin
			cn = {entry.col[7], entry.col};
			rn = {entry.row[7], entry.row};
		end else begin
			case (cfg.rotation)
				ttw_pkg::ROT_NONE: begin
					cn = c9 + step;
					if (cn > w9 || brk) begin
						cn = 9'sd0;
						rn = r9 + 9'sd1;
						if (rn > h9) begin
							rn = 9'sd0;
						end
					end
				end
				ttw_pkg::ROT_CW: begin
					rn = r9 + step;
					if (rn > h9 || brk) begin
						rn = 9'sd0;
						cn = c9 - 9'sd1;
						if (cn < 9'sd0) begin
							cn = w9;
						end
					end
				end
				ttw_pkg::ROT_CCW: begin
					rn = r9 - step;
					if (rn < 9'sd0 || brk) begin
						rn = h9;
						cn = c9 + 9'sd1;
						if (cn > w9) begin
							cn = 9'sd0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
			cur_col_q   <= 8'd0;
			cur_row_q   <= 8'd0;
		end else begin
			if (load_second || pop_print) begin
				out_valid_q <= 1'b1;
			end else if (tiles.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop_print) begin
				half_q <= 1'b1;
			end else if (load_second) begin
				half_q <= 1'b0;
			end
			if (pop) begin
				cur_col_q <= cn[7:0];
				cur_row_q <= rn[7:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_print) begin
			col_q   <= col_a;
			row_q   <= row_a;
			tile_q  <= {cfg.palette, TILE_PAD'(tile_a)};
			last_q  <= 1'b0;
			col2_q  <= col_b;
			row2_q  <= row_b;
			tile2_q <= {cfg.palette, TILE_PAD'(tile_b)};
		end else if (load_second) begin
			col_q  <= col2_q;
			row_q  <= row2_q;
			tile_q <= tile2_q;
			last_q <= 1'b1;
		end
	end

`ifndef SYNTH
	a_half_held: assert property (@(posedge clk) disable iff (!arst_n)
		half_q |-> out_valid_q)
		else $error("bottom write pending without a top write on the output");
	a_top_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(half_q) |-> out_valid_q && !last_q)
		else $error("top write not marked as first");
	a_bottom_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> !half_q)
		else $error("bottom write shown while another one is pending");
`endif
endmodule
